/* hw/rtl/pfma_pkg.sv */
// pfma_pkg: shared types, register and function codes for the pooling engine
// used by the controller, the datapath, the top level and the checker
// depends on nothing
package pfma_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_POOL_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int FUNC_W = 2;
  localparam int CFG_W  = 7;
  localparam int CFG_AW = 3;
  localparam int STRIDE_MAX = 8;

  // signed width for window positions and output dimension checks
  localparam int POS_W = 12;
  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_MAX   = 2'd1,
    FUNC_AVG   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_IN_ROWS     = 3'd0,
    REG_IN_COLS     = 3'd1,
    REG_POOL_ROWS   = 3'd2,
    REG_POOL_COLS   = 3'd3,
    REG_PAD_ROWS    = 3'd4,
    REG_PAD_COLS    = 3'd5,
    REG_STRIDE_ROWS = 3'd6,
    REG_STRIDE_COLS = 3'd7
  } reg_e;

  // register reset values
  localparam logic [6:0] IN_ROWS_RST     = 7'd64;
  localparam logic [6:0] IN_COLS_RST     = 7'd64;
  localparam logic [3:0] POOL_ROWS_RST   = 4'd2;
  localparam logic [3:0] POOL_COLS_RST   = 4'd2;
  localparam logic [2:0] PAD_ROWS_RST    = 3'd0;
  localparam logic [2:0] PAD_COLS_RST    = 3'd0;
  localparam logic [3:0] STRIDE_ROWS_RST = 4'd2;
  localparam logic [3:0] STRIDE_COLS_RST = 4'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr;        // store one pixel
    logic load;      // capture a query
    logic setup;     // range check, window origin, divisor
    logic step;      // read one window position
    logic div_load;  // take the window sum into the divider
    logic div_step;  // one quotient bit
  } pfma_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic oob;
    logic walk_last;
    logic is_avg;
    logic div_last;
  } pfma_sts_t;

endpackage

/* hw/rtl/pfma_ctrl.sv */
// pfma_ctrl: sequencing state machine of the pooling engine
// drives datapath commands from start/func and datapath status
// depends on pfma_pkg
module pfma_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pfma_pkg::FUNC_W-1:0]  func_i,
  input  pfma_pkg::pfma_sts_t          sts_i,
  output pfma_pkg::pfma_cmd_t          cmd_o,
  output logic                         busy_o,
  output logic                         done_o
);
  import pfma_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_LAST  = 7'b0001000,
    ST_PREP  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (func_i == FUNC_WRITE) begin
            cmd_o.wr = 1'b1;
          end else if (func_i inside {FUNC_MAX, FUNC_AVG}) begin
            cmd_o.load = 1'b1;
            state_d    = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.oob ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_LAST;
        end
      end
      // last read data lands in the accumulator here
      ST_LAST: begin
        state_d = sts_i.is_avg ? ST_PREP : ST_DONE;
      end
      ST_PREP: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/pfma_dp.sv */
// pfma_dp: datapath of the pooling engine: config registers, frame store,
// window walker, max/sum accumulator and a restoring divider for averages
// depends on pfma_pkg
module pfma_dp #(
  parameter int MAX_ROWS    = pfma_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = pfma_pkg::MAX_COLS_DEF,
  parameter int MAX_POOL    = pfma_pkg::MAX_POOL_DEF,
  parameter int SAMPLE_BITS = pfma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfma_pkg::pfma_cmd_t           cmd_i,
  output pfma_pkg::pfma_sts_t           sts_o,
  input  logic [pfma_pkg::FUNC_W-1:0]   func_i,
  input  logic [pfma_pkg::ROW_W-1:0]    row_i,
  input  logic [pfma_pkg::COL_W-1:0]    col_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          cfg_we_i,
  input  logic [pfma_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [pfma_pkg::CFG_W-1:0]    cfg_data_i,
  output logic signed [SAMPLE_BITS-1:0] pooled_value_o,
  output logic                          out_of_range_o
);
  import pfma_pkg::*;

  localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AD_W  = RA_W + CA_W;
  localparam int DEPTH = 1 << AD_W;
  localparam int ACC_W = SAMPLE_BITS + $clog2(MAX_POOL * MAX_POOL);
  localparam int CNT_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int DVS_W = $clog2(MAX_POOL * MAX_POOL + 1);
  localparam int DC_W  = $clog2(ACC_W + 1);

  // ---------------- configuration registers ----------------
  logic [6:0] in_rows_q, in_cols_q;
  logic [3:0] pool_rows_q, pool_cols_q, stride_rows_q, stride_cols_q;
  logic [2:0] pad_rows_q, pad_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rows_q     <= IN_ROWS_RST;
      in_cols_q     <= IN_COLS_RST;
      pool_rows_q   <= POOL_ROWS_RST;
      pool_cols_q   <= POOL_COLS_RST;
      pad_rows_q    <= PAD_ROWS_RST;
      pad_cols_q    <= PAD_COLS_RST;
      stride_rows_q <= STRIDE_ROWS_RST;
      stride_cols_q <= STRIDE_COLS_RST;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_IN_ROWS:     in_rows_q     <= cfg_data_i;
        REG_IN_COLS:     in_cols_q     <= cfg_data_i;
        REG_POOL_ROWS:   pool_rows_q   <= cfg_data_i[3:0];
        REG_POOL_COLS:   pool_cols_q   <= cfg_data_i[3:0];
        REG_PAD_ROWS:    pad_rows_q    <= cfg_data_i[2:0];
        REG_PAD_COLS:    pad_cols_q    <= cfg_data_i[2:0];
        REG_STRIDE_ROWS: stride_rows_q <= cfg_data_i[3:0];
        REG_STRIDE_COLS: stride_cols_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  function automatic pos_t clamp(pos_t v, pos_t hi);
    pos_t r;
    if (v < pos_t'(1)) begin
      r = pos_t'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  pos_t irows, icols, prows, pcols, drows, dcols, srows, scols;

  always_comb begin
    irows = clamp(pos_t'(in_rows_q), pos_t'(MAX_ROWS));
    icols = clamp(pos_t'(in_cols_q), pos_t'(MAX_COLS));
    prows = clamp(pos_t'(pool_rows_q), pos_t'(MAX_POOL));
    pcols = clamp(pos_t'(pool_cols_q), pos_t'(MAX_POOL));
    srows = clamp(pos_t'(stride_rows_q), pos_t'(STRIDE_MAX));
    scols = clamp(pos_t'(stride_cols_q), pos_t'(STRIDE_MAX));
    drows = pos_t'(pad_rows_q);
    dcols = pos_t'(pad_cols_q);
  end

  // ---------------- query capture ----------------
  logic [ROW_W-1:0] q_row_q;
  logic [COL_W-1:0] q_col_q;
  logic             is_avg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_row_q  <= row_i;
      q_col_q  <= col_i;
      is_avg_q <= (func_i == FUNC_AVG);
    end
  end

  // ---------------- range check and window origin ----------------
  pos_t row_scaled, col_scaled, n_rows, n_cols, org_r, org_c;
  logic oob;

  always_comb begin
    row_scaled = pos_t'(q_row_q) * srows;
    col_scaled = pos_t'(q_col_q) * scols;
    n_rows     = irows + (drows <<< 1) - prows + pos_t'(1);
    n_cols     = icols + (dcols <<< 1) - pcols + pos_t'(1);
    // row >= ceil(n/stride) exactly when row*stride >= n, also for n <= 0
    oob        = (row_scaled >= n_rows) || (col_scaled >= n_cols);
    org_r      = row_scaled - drows;
    org_c      = col_scaled - dcols;
  end

  // ---------------- window walker ----------------
  pos_t             r_q, c_q, orgc_q;
  logic [CNT_W-1:0] i_q, j_q;
  logic             oob_q;
  logic [DVS_W-1:0] divisor_q;
  logic             row_end, walk_last, in_plane;

  assign row_end   = (pos_t'(j_q) == pcols - pos_t'(1));
  assign walk_last = row_end && (pos_t'(i_q) == prows - pos_t'(1));
  assign in_plane  = (r_q >= pos_t'(0)) && (r_q < irows) &&
                     (c_q >= pos_t'(0)) && (c_q < icols);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      r_q       <= org_r;
      c_q       <= org_c;
      orgc_q    <= org_c;
      i_q       <= '0;
      j_q       <= '0;
      oob_q     <= oob;
      divisor_q <= DVS_W'(prows * pcols);
    end else if (cmd_i.step) begin
      if (row_end) begin
        j_q <= '0;
        c_q <= orgc_q;
        i_q <= i_q + CNT_W'(1);
        r_q <= r_q + pos_t'(1);
      end else begin
        j_q <= j_q + CNT_W'(1);
        c_q <= c_q + pos_t'(1);
      end
    end
  end

  // ---------------- frame store ----------------
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  pos_t                          wrow, wcol;
  logic                          wr_ok;
  logic [AD_W-1:0]               waddr, raddr;

  assign wrow  = pos_t'(row_i);
  assign wcol  = pos_t'(col_i);
  assign wr_ok = (wrow < pos_t'(MAX_ROWS)) && (wcol < pos_t'(MAX_COLS));
  assign waddr = {wrow[RA_W-1:0], wcol[CA_W-1:0]};
  assign raddr = {r_q[RA_W-1:0], c_q[CA_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem[waddr] <= sample_i;
    end
    if (cmd_i.step && in_plane) begin
      rd_data_q <= mem[raddr];
    end
  end

  // read data tracking: padded positions count as zero
  logic rd_valid_q, pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pad_q <= !in_plane;
    end
  end

  // ---------------- accumulator ----------------
  logic signed [ACC_W-1:0] acc_q, acc_d, v;
  logic                    first_q;

  always_comb begin
    v     = pad_q ? '0 : ACC_W'(rd_data_q);
    acc_d = acc_q;
    if (is_avg_q) begin
      acc_d = acc_q + v;
    end else if (first_q || (v > acc_q)) begin
      acc_d = v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      acc_q   <= '0;
      first_q <= 1'b1;
    end else if (rd_valid_q) begin
      acc_q   <= acc_d;
      first_q <= 1'b0;
    end
  end

  // ---------------- restoring divider on the magnitude ----------------
  logic [ACC_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   rem_sh;
  logic [DC_W-1:0]  dcnt_q;
  logic             neg_q, fits;

  assign rem_sh = {rem_q, quo_q[ACC_W-1]};
  assign fits   = (rem_sh >= {1'b0, divisor_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_q  <= acc_q[ACC_W-1];
      quo_q  <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
      rem_q  <= '0;
      dcnt_q <= DC_W'(ACC_W);
    end else if (cmd_i.div_step) begin
      if (fits) begin
        rem_q <= DVS_W'(rem_sh - {1'b0, divisor_q});
      end else begin
        rem_q <= rem_sh[DVS_W-1:0];
      end
      quo_q  <= {quo_q[ACC_W-2:0], fits};
      dcnt_q <= dcnt_q - DC_W'(1);
    end
  end

  // ---------------- result and status ----------------
  logic signed [SAMPLE_BITS-1:0] avg_val;

  assign avg_val = neg_q ? -quo_q[SAMPLE_BITS-1:0] : quo_q[SAMPLE_BITS-1:0];

  always_comb begin
    if (oob_q) begin
      pooled_value_o = '0;
    end else if (is_avg_q) begin
      pooled_value_o = avg_val;
    end else begin
      pooled_value_o = acc_q[SAMPLE_BITS-1:0];
    end
  end

  assign out_of_range_o  = oob_q;
  assign sts_o.oob       = oob;
  assign sts_o.walk_last = walk_last;
  assign sts_o.is_avg    = is_avg_q;
  assign sts_o.div_last  = (dcnt_q == DC_W'(1));

endmodule

/* hw/rtl/pooling_forward_max_avg_core.sv */
// pooling_forward_max_avg_core: max / average pooling engine over one plane
// top level joining pfma_ctrl and pfma_dp
// depends on pfma_pkg, pfma_ctrl, pfma_dp
//
// usage: an item is taken at a clock edge with start high and busy low.
// func write stores sample at (row, col) at that edge, busy stays low and
// writes may follow every cycle; they give no result. max and average
// queries name an output coordinate and raise busy; func 3 is taken and
// dropped. the result shows on pooled_value_o / out_of_range_o for one
// cycle with done_o high, and busy falls the cycle after.
// after the accept edge, out of range: range check, strobe; max: range
// check, window walk (one frame store read per cycle), strobe; average:
// as max, but divides before the strobe, one quotient bit a cycle, into
// ACC_W = SAMPLE_BITS + clog2(MAX_POOL^2) bits (22 by default). the next
// query may start as soon as busy is low again. the config port writes
// one register per cycle with cfg_we_i; the user must write only while
// busy is low, which the block does not enforce. reset loads the
// register defaults and idles the sequencer; the frame store is not
// cleared. the receiver cannot stall the strobe.
module pooling_forward_max_avg_core #(
  parameter int MAX_ROWS    = pfma_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = pfma_pkg::MAX_COLS_DEF,
  parameter int MAX_POOL    = pfma_pkg::MAX_POOL_DEF,
  parameter int SAMPLE_BITS = pfma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pfma_pkg::FUNC_W-1:0]   func_i,
  input  logic [pfma_pkg::ROW_W-1:0]    row_i,
  input  logic [pfma_pkg::COL_W-1:0]    col_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          cfg_we_i,
  input  logic [pfma_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [pfma_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] pooled_value_o,
  output logic                          out_of_range_o
);
  import pfma_pkg::*;

  pfma_cmd_t cmd;
  pfma_sts_t sts;

  pfma_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  pfma_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .MAX_POOL    (MAX_POOL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .sample_i       (sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .pooled_value_o (pooled_value_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

/* hw/rtl/pfma_checker.sv */
// pfma_checker: port-level assertions for the pooling engine, bound to the top
// watches the command handshake and the result strobe
// depends on pfma_pkg and pooling_forward_max_avg_core
module pfma_checker #(
  parameter int SAMPLE_BITS = pfma_pkg::SAMPLE_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_i,
  input logic [pfma_pkg::FUNC_W-1:0]  func_i,
  input logic                         done_i,
  input logic [SAMPLE_BITS-1:0]       pooled_value_i,
  input logic                         out_of_range_i
);
  import pfma_pkg::*;

  // a query transfer always occupies the engine
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (func_i == FUNC_MAX || func_i == FUNC_AVG) |=> busy_i)
    else $error("query accepted but busy did not rise");

  // the strobe only comes from a running query
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> busy_i)
    else $error("result strobe while idle");

  // busy only drops right after a result was delivered
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> $past(done_i))
    else $error("busy fell without a result");

  // out of range results carry a zero value
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && out_of_range_i |-> pooled_value_i == '0)
    else $error("out of range result with nonzero value");

endmodule

bind pooling_forward_max_avg_core pfma_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_pfma_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .func_i         (func_i),
  .done_i         (done_o),
  .pooled_value_i (pooled_value_o),
  .out_of_range_i (out_of_range_o)
);

/* tb/pfma_checker.sv */
// pfma_scoreboard: follows item, config and result transfers of the pooling engine,
// keeps its own frame store and register copy, and checks each result strobe
// depends on pfma_pkg
module pfma_scoreboard (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic                                        busy_i,
  input  logic [pfma_pkg::FUNC_W-1:0]                 func_i,
  input  logic [pfma_pkg::ROW_W-1:0]                  row_i,
  input  logic [pfma_pkg::COL_W-1:0]                  col_i,
  input  logic signed [pfma_pkg::SAMPLE_BITS_DEF-1:0] sample_i,
  input  logic                                        cfg_we_i,
  input  logic [pfma_pkg::CFG_AW-1:0]                 cfg_addr_i,
  input  logic [pfma_pkg::CFG_W-1:0]                  cfg_data_i,
  input  logic                                        done_i,
  input  logic signed [pfma_pkg::SAMPLE_BITS_DEF-1:0] pooled_value_i,
  input  logic                                        out_of_range_i,
  output int                                          fail_count_o,
  output int                                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfma_pkg::*;

  localparam int PIX_W = SAMPLE_BITS_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             oor;
  } pooled_t;

  logic [CFG_W-1:0] cfg_q [8];
  logic [PIX_W-1:0] frame_mem [MAX_ROWS_DEF*MAX_COLS_DEF];
  pooled_t          pooled_q [$];
  int               mismatches = 0;
  int               outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int out_extent(int plane, int pool, int pad, int stride);
    int n;
    n = plane + 2 * pad - pool + 1;
    if (n <= 0) return 0;
    return (n + stride - 1) / stride;
  endfunction

  function automatic logic [CFG_W-1:0] cfg_mask(reg_e idx);
    case (idx)
      REG_IN_ROWS, REG_IN_COLS: return 7'h7f;
      REG_PAD_ROWS, REG_PAD_COLS: return 7'h07;
      default: return 7'h0f;
    endcase
  endfunction

  function automatic pooled_t pool_window(func_e op, int orow, int ocol);
    int irows, icols, prows, pcols, drows, dcols, srows, scols;
    int acc, pix, r, c, i, j;
    bit seen;
    pooled_t res;
    irows = clip(cfg_q[REG_IN_ROWS], 1, MAX_ROWS_DEF);
    icols = clip(cfg_q[REG_IN_COLS], 1, MAX_COLS_DEF);
    prows = clip(cfg_q[REG_POOL_ROWS], 1, MAX_POOL_DEF);
    pcols = clip(cfg_q[REG_POOL_COLS], 1, MAX_POOL_DEF);
    drows = cfg_q[REG_PAD_ROWS];
    dcols = cfg_q[REG_PAD_COLS];
    srows = clip(cfg_q[REG_STRIDE_ROWS], 1, STRIDE_MAX);
    scols = clip(cfg_q[REG_STRIDE_COLS], 1, STRIDE_MAX);
    res = '0;
    if (orow >= out_extent(irows, prows, drows, srows) ||
        ocol >= out_extent(icols, pcols, dcols, scols)) begin
      res.oor = 1'b1;
      return res;
    end
    acc = 0;
    seen = 1'b0;
    for (i = 0; i < prows; i++) begin
      r = orow * srows + i - drows;
      for (j = 0; j < pcols; j++) begin
        c = ocol * scols + j - dcols;
        pix = 0;
        // padding reads as zero
        if (r >= 0 && r < irows && c >= 0 && c < icols)
          pix = $signed(frame_mem[r * MAX_COLS_DEF + c]);
        if (op == FUNC_MAX) begin
          if (!seen || pix > acc) acc = pix;
          seen = 1'b1;
        end else begin
          acc += pix;
        end
      end
    end
    // int division truncates toward zero
    if (op == FUNC_AVG) acc = acc / (prows * pcols);
    res.value = acc[PIX_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_t exp_res;
    if (!rst_ni) begin
      cfg_q[REG_IN_ROWS]     = IN_ROWS_RST;
      cfg_q[REG_IN_COLS]     = IN_COLS_RST;
      cfg_q[REG_POOL_ROWS]   = CFG_W'(POOL_ROWS_RST);
      cfg_q[REG_POOL_COLS]   = CFG_W'(POOL_COLS_RST);
      cfg_q[REG_PAD_ROWS]    = CFG_W'(PAD_ROWS_RST);
      cfg_q[REG_PAD_COLS]    = CFG_W'(PAD_COLS_RST);
      cfg_q[REG_STRIDE_ROWS] = CFG_W'(STRIDE_ROWS_RST);
      cfg_q[REG_STRIDE_COLS] = CFG_W'(STRIDE_COLS_RST);
      pooled_q.delete();
      outstanding = 0;
    end else begin
      if (done_i) begin
        if (pooled_q.size() == 0) begin
          $error("result with no query outstanding: pooled_value %0d out_of_range %0b",
                 pooled_value_i, out_of_range_i);
          mismatches++;
        end else begin
          exp_res = pooled_q.pop_front();
          outstanding--;
          if (pooled_value_i !== exp_res.value) begin
            $error("pooled_value: expected %0d, got %0d", $signed(exp_res.value),
                   pooled_value_i);
            mismatches++;
          end
          if (out_of_range_i !== exp_res.oor) begin
            $error("out_of_range: expected %0b, got %0b", exp_res.oor, out_of_range_i);
            mismatches++;
          end
        end
      end
      if (cfg_we_i)
        cfg_q[cfg_addr_i] = cfg_data_i & cfg_mask(reg_e'(cfg_addr_i));
      if (start_i && !busy_i) begin
        case (func_e'(func_i))
          FUNC_WRITE: frame_mem[row_i * MAX_COLS_DEF + col_i] = sample_i;
          FUNC_MAX, FUNC_AVG: begin
            pooled_q.push_back(pool_window(func_e'(func_i), row_i, col_i));
            outstanding++;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_pooling_forward_max_avg_core.sv */
// tb_pooling_forward_max_avg_core: stimulus and verdict for the pooling engine,
// directed corner items then random config phases of writes and queries
// depends on pfma_pkg, pooling_forward_max_avg_core and pfma_scoreboard
module tb_pooling_forward_max_avg_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pfma_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 100;
  localparam int ITEM_TARGET    = 1750;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [FUNC_W-1:0]                 func_i = '0;
  logic [ROW_W-1:0]                  row_i = '0;
  logic [COL_W-1:0]                  col_i = '0;
  logic signed [SAMPLE_BITS_DEF-1:0] sample_i = '0;
  logic                              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]                 cfg_addr_i = '0;
  logic [CFG_W-1:0]                  cfg_data_i = '0;
  logic                              done_o;
  logic signed [SAMPLE_BITS_DEF-1:0] pooled_value_o;
  logic                              out_of_range_o;

  int               fail_count;
  int               pending;
  int               idle_cycles = 0;
  int               item_count = 0;
  bit               steady = 1'b0;
  logic [CFG_W-1:0] cfg_raw [8];
  bit               written [MAX_ROWS_DEF*MAX_COLS_DEF];

  pooling_forward_max_avg_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .sample_i       (sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .pooled_value_o (pooled_value_o),
    .out_of_range_o (out_of_range_o)
  );

  pfma_scoreboard u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .sample_i       (sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .done_i         (done_o),
    .pooled_value_i (pooled_value_o),
    .out_of_range_i (out_of_range_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // a cycle counts as idle when neither an item nor a result is transferred
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // effective register value after width masking and saturation
  function automatic int eff(reg_e idx);
    int v;
    case (idx)
      REG_IN_ROWS: v = (cfg_raw[idx] > MAX_ROWS_DEF) ? MAX_ROWS_DEF : cfg_raw[idx];
      REG_IN_COLS: v = (cfg_raw[idx] > MAX_COLS_DEF) ? MAX_COLS_DEF : cfg_raw[idx];
      REG_POOL_ROWS, REG_POOL_COLS:
        v = (cfg_raw[idx][3:0] > MAX_POOL_DEF) ? MAX_POOL_DEF : cfg_raw[idx][3:0];
      REG_PAD_ROWS, REG_PAD_COLS: v = cfg_raw[idx][2:0];
      default: v = (cfg_raw[idx][3:0] > STRIDE_MAX) ? STRIDE_MAX : cfg_raw[idx][3:0];
    endcase
    if (idx != REG_PAD_ROWS && idx != REG_PAD_COLS && v < 1) v = 1;
    return v;
  endfunction

  function automatic int out_extent(int plane, int pool, int pad, int stride);
    int n;
    n = plane + 2 * pad - pool + 1;
    if (n <= 0) return 0;
    return (n + stride - 1) / stride;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(-$urandom_range(1, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // one item transfer; returns at the accepting edge with start still high
  task automatic send_item(func_e op, int row, int col, logic [15:0] value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    func_i   <= op;
    row_i    <= row[ROW_W-1:0];
    col_i    <= col[COL_W-1:0];
    sample_i <= value;
    do @(posedge clk_i); while (busy);
    if (op == FUNC_WRITE) written[row * MAX_COLS_DEF + col] = 1'b1;
    if (op != FUNC_NONE) item_count++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic program_regs();
    wait_drained();
    // writes and dropped items give no strobe, let them settle
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= reg_e'(k);
      cfg_data_i <= cfg_raw[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [6:0] in_r, logic [6:0] in_c, logic [6:0] pool_r,
                          logic [6:0] pool_c, logic [6:0] pad_r, logic [6:0] pad_c,
                          logic [6:0] str_r, logic [6:0] str_c);
    cfg_raw[REG_IN_ROWS]     = in_r;
    cfg_raw[REG_IN_COLS]     = in_c;
    cfg_raw[REG_POOL_ROWS]   = pool_r;
    cfg_raw[REG_POOL_COLS]   = pool_c;
    cfg_raw[REG_PAD_ROWS]    = pad_r;
    cfg_raw[REG_PAD_COLS]    = pad_c;
    cfg_raw[REG_STRIDE_ROWS] = str_r;
    cfg_raw[REG_STRIDE_COLS] = str_c;
    program_regs();
  endtask

  // fills any unwritten pixel the window will read, then issues the query
  task automatic run_query(func_e op, int orow, int ocol);
    int irows, icols, prows, pcols, drows, dcols, srows, scols, r, c;
    irows = eff(REG_IN_ROWS);
    icols = eff(REG_IN_COLS);
    prows = eff(REG_POOL_ROWS);
    pcols = eff(REG_POOL_COLS);
    drows = eff(REG_PAD_ROWS);
    dcols = eff(REG_PAD_COLS);
    srows = eff(REG_STRIDE_ROWS);
    scols = eff(REG_STRIDE_COLS);
    if (orow < out_extent(irows, prows, drows, srows) &&
        ocol < out_extent(icols, pcols, dcols, scols)) begin
      for (int i = 0; i < prows; i++) begin
        for (int j = 0; j < pcols; j++) begin
          r = orow * srows + i - drows;
          c = ocol * scols + j - dcols;
          if (r >= 0 && r < irows && c >= 0 && c < icols &&
              !written[r * MAX_COLS_DEF + c])
            send_item(FUNC_WRITE, r, c, rand_sample());
        end
      end
    end
    send_item(op, orow, ocol, rand_sample());
  endtask

  task automatic pick_config();
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        cfg_raw[k] = $urandom_range(0, 127);
      end else begin
        case (reg_e'(k))
          REG_IN_ROWS, REG_IN_COLS: begin
            case ($urandom_range(0, 9))
              0: cfg_raw[k] = 7'd64;
              1: cfg_raw[k] = 7'd1;
              default: cfg_raw[k] = $urandom_range(1, 12);
            endcase
          end
          REG_POOL_ROWS, REG_POOL_COLS: cfg_raw[k] = $urandom_range(1, MAX_POOL_DEF);
          REG_PAD_ROWS, REG_PAD_COLS:
            cfg_raw[k] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                     : $urandom_range(0, 3);
          default:
            cfg_raw[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, STRIDE_MAX)
                                                     : $urandom_range(1, 3);
        endcase
      end
    end
    program_regs();
  endtask

  task automatic run_phase(int len);
    int sel, dim_r, dim_c, orow, ocol;
    func_e op;
    dim_r = out_extent(eff(REG_IN_ROWS), eff(REG_POOL_ROWS), eff(REG_PAD_ROWS),
                       eff(REG_STRIDE_ROWS));
    dim_c = out_extent(eff(REG_IN_COLS), eff(REG_POOL_COLS), eff(REG_PAD_COLS),
                       eff(REG_STRIDE_COLS));
    if (dim_r > 64) dim_r = 64;
    if (dim_c > 64) dim_c = 64;
    for (int k = 0; k < len && item_count < ITEM_TARGET; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        op = $urandom_range(0, 1) ? FUNC_MAX : FUNC_AVG;
        if (dim_r > 0 && dim_c > 0 && $urandom_range(0, 99) < 85) begin
          orow = $urandom_range(0, dim_r - 1);
          ocol = $urandom_range(0, dim_c - 1);
        end else begin
          orow = $urandom_range(0, 63);
          ocol = $urandom_range(0, 63);
        end
        run_query(op, orow, ocol);
      end else if (sel < 85) begin
        send_item(FUNC_WRITE, $urandom_range(0, eff(REG_IN_ROWS) - 1),
                  $urandom_range(0, eff(REG_IN_COLS) - 1), rand_sample());
      end else if (sel < 94) begin
        send_item(FUNC_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), rand_sample());
      end else if (sel < 97) begin
        send_item(FUNC_NONE, $urandom_range(0, 63), $urandom_range(0, 63), rand_sample());
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    cfg_raw[REG_IN_ROWS]     = IN_ROWS_RST;
    cfg_raw[REG_IN_COLS]     = IN_COLS_RST;
    cfg_raw[REG_POOL_ROWS]   = CFG_W'(POOL_ROWS_RST);
    cfg_raw[REG_POOL_COLS]   = CFG_W'(POOL_COLS_RST);
    cfg_raw[REG_PAD_ROWS]    = CFG_W'(PAD_ROWS_RST);
    cfg_raw[REG_PAD_COLS]    = CFG_W'(PAD_COLS_RST);
    cfg_raw[REG_STRIDE_ROWS] = CFG_W'(STRIDE_ROWS_RST);
    cfg_raw[REG_STRIDE_COLS] = CFG_W'(STRIDE_COLS_RST);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: extreme samples, average that truncates toward zero
    send_item(FUNC_WRITE, 0, 0, 16'h7fff);
    send_item(FUNC_WRITE, 0, 1, 16'h8000);
    send_item(FUNC_WRITE, 1, 0, 16'h0000);
    send_item(FUNC_WRITE, 1, 1, 16'hffff);
    run_query(FUNC_MAX, 0, 0);
    run_query(FUNC_AVG, 0, 0);
    send_item(FUNC_WRITE, 62, 62, 16'h8000);
    send_item(FUNC_WRITE, 62, 63, 16'h8000);
    send_item(FUNC_WRITE, 63, 62, 16'h8000);
    send_item(FUNC_WRITE, 63, 63, 16'h8000);
    run_query(FUNC_MAX, 31, 31);
    run_query(FUNC_AVG, 31, 31);
    run_query(FUNC_MAX, 32, 0);
    run_query(FUNC_AVG, 0, 63);
    send_item(FUNC_NONE, 63, 63, 16'h5a5a);

    // all but the pad registers outside their range, saturating at both ends
    set_regs(7'd0, 7'h7f, 7'd0, 7'h7f, 7'd7, 7'd7, 7'd0, 7'h7f);
    run_query(FUNC_MAX, 7, 0);
    run_query(FUNC_AVG, 7, 8);
    run_query(FUNC_MAX, 15, 0);

    // window larger than the plane: empty output
    set_regs(7'd1, 7'd1, 7'd8, 7'd8, 7'd0, 7'd0, 7'd1, 7'd1);
    run_query(FUNC_MAX, 0, 0);
    run_query(FUNC_AVG, 0, 0);

    // full padding around a negative pixel
    set_regs(7'd1, 7'd1, 7'd8, 7'd8, 7'd7, 7'd7, 7'd1, 7'd1);
    send_item(FUNC_WRITE, 0, 0, 16'h8000);
    run_query(FUNC_MAX, 0, 0);
    run_query(FUNC_AVG, 7, 7);

    while (item_count < ITEM_TARGET) begin
      pick_config();
      steady = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(40, 160));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
